// ===== hw/rtl/fdvs_pkg.sv =====
// shared types, constants and encodings of the finite domain value store
package fdvs_pkg;

  localparam int ValW       = 8;
  localparam int OpW        = 3;
  localparam int EvW        = 4;
  localparam int DomainSize = 256;
  localparam int RowW       = 16;
  localparam int RowBitW    = $clog2(RowW);
  localparam int NumRows    = DomainSize / RowW;
  localparam int RowIdxW    = $clog2(NumRows);

  localparam logic [ValW-1:0] MaxVal = ValW'(DomainSize - 1);

  localparam logic [EvW-1:0] EvChanged = 4'b0001;
  localparam logic [EvW-1:0] EvLower   = 4'b0010;
  localparam logic [EvW-1:0] EvUpper   = 4'b0100;
  localparam logic [EvW-1:0] EvFixed   = 4'b1000;

  typedef enum logic [OpW-1:0] {
    OpInit        = 3'd0,
    OpRaiseMin    = 3'd1,
    OpLowerMax    = 3'd2,
    OpFixValue    = 3'd3,
    OpRemoveValue = 3'd4,
    OpTakeEvents  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StRefresh,
    StScanUp,
    StScanDn,
    StFinish
  } state_e;

  typedef struct packed {
    logic capture;
    logic set_fail;
    logic do_init;
    logic low_to_v;
    logic high_to_v;
    logic do_fix;
    logic do_remove;
    logic scan_up;
    logic scan_dn;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           v_gt_vh;
    logic           v_le_low;
    logic           v_gt_high;
    logic           v_ge_high;
    logic           v_lt_low;
    logic           pres_v;
    logic           in_dom;
    logic           lo_eq_hi;
    logic           v_eq_low;
    logic           v_eq_high;
    logic           up_done;
    logic           dn_done;
    logic           out_free;
  } status_t;

  function automatic logic [ValW-1:0] clamp_val(input logic [ValW-1:0] v);
    clamp_val = (v > MaxVal) ? MaxVal : v;
  endfunction

endpackage

// ===== hw/rtl/fdvs_if.sv =====
// operation and result channels of the finite domain value store
interface fdvs_in_if;
  logic                          valid;
  logic                          ready;
  logic [fdvs_pkg::OpW-1:0]      opcode;
  logic [fdvs_pkg::ValW-1:0]     value;
  logic [fdvs_pkg::ValW-1:0]     value_high;

  modport source (output valid, output opcode, output value, output value_high, input ready);
  modport sink   (input valid, input opcode, input value, input value_high, output ready);
endinterface

interface fdvs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [fdvs_pkg::ValW-1:0]     lower;
  logic [fdvs_pkg::ValW-1:0]     upper;
  logic                          is_fixed;
  logic [fdvs_pkg::EvW-1:0]      events;

  modport source (output valid, output ok, output lower, output upper, output is_fixed,
                  output events, input ready);
  modport sink   (input valid, input ok, input lower, input upper, input is_fixed,
                  input events, output ready);
endinterface

// ===== hw/rtl/fdvs_datapath.sv =====
// bounds, flags, presence bitmap rows, row scanner and result register
module fdvs_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fdvs_pkg::cmd_t                 cmd_i,
  output fdvs_pkg::status_t              status_o,
  input  logic [fdvs_pkg::OpW-1:0]       opcode_i,
  input  logic [fdvs_pkg::ValW-1:0]      value_i,
  input  logic [fdvs_pkg::ValW-1:0]      value_high_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           ok_o,
  output logic [fdvs_pkg::ValW-1:0]      lower_o,
  output logic [fdvs_pkg::ValW-1:0]      upper_o,
  output logic                           is_fixed_o,
  output logic [fdvs_pkg::EvW-1:0]       events_o
);

  localparam int ValW    = fdvs_pkg::ValW;
  localparam int RowW    = fdvs_pkg::RowW;
  localparam int RowBitW = fdvs_pkg::RowBitW;
  localparam int RowIdxW = fdvs_pkg::RowIdxW;
  localparam int NumRows = fdvs_pkg::NumRows;
  localparam int EvW     = fdvs_pkg::EvW;

  // current item
  logic [fdvs_pkg::OpW-1:0] op_q;
  logic [ValW-1:0]          v_q, vh_q;
  logic                     ok_q, ok_d;

  // domain state
  logic [ValW-1:0]          low_q, low_d, high_q, high_d;
  logic [EvW-1:0]           flags_q, flags_d;
  logic [NumRows-1:0]       row_vld_q, row_vld_d;

  // bitmap memory and its read side
  logic [RowW-1:0]          mem_q [NumRows];
  logic [RowW-1:0]          rdata_q;
  logic                     rvld_q;
  logic [RowIdxW-1:0]       row_q, row_d;
  logic [RowW-1:0]          eff_row, wdata;
  logic                     wr_en;

  // scanner
  logic [RowIdxW-1:0]       low_row, high_row;
  logic [RowBitW-1:0]       v_bit, up_start, dn_end, up_idx, dn_idx;
  logic [RowW-1:0]          hits_up, hits_dn;
  logic                     any_up, any_dn, up_done, dn_done;
  logic [ValW-1:0]          up_cand, dn_cand, new_low, new_high;
  logic [ValW-1:0]          v_in;

  // result register
  logic                     out_valid_q;
  logic                     res_ok_q, res_fixed_q;
  logic [ValW-1:0]          res_low_q, res_high_q;
  logic [EvW-1:0]           res_ev_q;

  assign v_in     = fdvs_pkg::clamp_val(value_i);
  assign v_bit    = v_q[RowBitW-1:0];
  assign low_row  = low_q[ValW-1 -: RowIdxW];
  assign high_row = high_q[ValW-1 -: RowIdxW];

  // rows never written since the last init read as all present
  assign eff_row  = rvld_q ? rdata_q : {RowW{1'b1}};

  // first present value at or above the lower bound in the current row
  assign up_start = (row_q == low_row) ? low_q[RowBitW-1:0] : '0;
  assign dn_end   = (row_q == high_row) ? high_q[RowBitW-1:0] : RowBitW'(RowW - 1);

  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      hits_up[i] = eff_row[i] && (RowBitW'(i) >= up_start);
      hits_dn[i] = eff_row[i] && (RowBitW'(i) <= dn_end);
    end
  end

  always_comb begin
    up_idx = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (hits_up[i]) begin
        up_idx = RowBitW'(i);
      end
    end
  end

  always_comb begin
    dn_idx = '0;
    for (int i = 0; i < RowW; i++) begin
      if (hits_dn[i]) begin
        dn_idx = RowBitW'(i);
      end
    end
  end

  assign any_up   = |hits_up;
  assign any_dn   = |hits_dn;
  assign up_cand  = {row_q, up_idx};
  assign dn_cand  = {row_q, dn_idx};
  assign up_done  = any_up || (row_q >= high_row);
  assign dn_done  = any_dn || (row_q <= low_row);
  assign new_low  = (any_up && (up_cand < high_q)) ? up_cand : high_q;
  assign new_high = (any_dn && (dn_cand > low_q)) ? dn_cand : low_q;

  // row pointer follows the operand, then walks during a scan
  always_comb begin
    row_d = row_q;
    if (cmd_i.capture) begin
      row_d = v_in[ValW-1 -: RowIdxW];
    end else if (cmd_i.scan_up && !up_done) begin
      row_d = row_q + RowIdxW'(1);
    end else if (cmd_i.scan_dn && !dn_done) begin
      row_d = row_q - RowIdxW'(1);
    end
  end

  assign wr_en = cmd_i.do_remove;
  assign wdata = eff_row & ~(RowW'(1) << v_bit);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[row_q] <= wdata;
    end
    rdata_q <= mem_q[row_d];
  end

  always_comb begin
    ok_d      = ok_q;
    low_d     = low_q;
    high_d    = high_q;
    flags_d   = flags_q;
    row_vld_d = row_vld_q;
    if (cmd_i.capture) begin
      ok_d = 1'b1;
    end
    if (cmd_i.set_fail) begin
      ok_d = 1'b0;
    end
    if (cmd_i.do_init) begin
      low_d     = v_q;
      high_d    = vh_q;
      flags_d   = fdvs_pkg::EvChanged | fdvs_pkg::EvLower | fdvs_pkg::EvUpper |
                  ((v_q == vh_q) ? fdvs_pkg::EvFixed : '0);
      row_vld_d = '0;
    end
    if (cmd_i.low_to_v) begin
      low_d   = v_q;
      flags_d = flags_q | fdvs_pkg::EvChanged | fdvs_pkg::EvLower |
                ((v_q == high_q) ? fdvs_pkg::EvFixed : '0);
    end
    if (cmd_i.high_to_v) begin
      high_d  = v_q;
      flags_d = flags_q | fdvs_pkg::EvChanged | fdvs_pkg::EvUpper |
                ((v_q == low_q) ? fdvs_pkg::EvFixed : '0);
    end
    if (cmd_i.do_fix) begin
      if (low_q < v_q) begin
        low_d   = v_q;
        flags_d = flags_d | fdvs_pkg::EvChanged | fdvs_pkg::EvLower | fdvs_pkg::EvFixed;
      end
      if (high_q > v_q) begin
        high_d  = v_q;
        flags_d = flags_d | fdvs_pkg::EvChanged | fdvs_pkg::EvUpper | fdvs_pkg::EvFixed;
      end
    end
    if (cmd_i.do_remove) begin
      flags_d          = flags_q | fdvs_pkg::EvChanged;
      row_vld_d[row_q] = 1'b1;
    end
    if (cmd_i.scan_up && up_done) begin
      low_d   = new_low;
      flags_d = flags_q | fdvs_pkg::EvChanged | fdvs_pkg::EvLower |
                ((new_low == high_q) ? fdvs_pkg::EvFixed : '0);
    end
    if (cmd_i.scan_dn && dn_done) begin
      high_d  = new_high;
      flags_d = flags_q | fdvs_pkg::EvChanged | fdvs_pkg::EvUpper |
                ((new_high == low_q) ? fdvs_pkg::EvFixed : '0);
    end
    if (cmd_i.finish && (op_q == fdvs_pkg::OpTakeEvents)) begin
      flags_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= fdvs_pkg::MaxVal;
      flags_q     <= '0;
      row_vld_q   <= '0;
      rvld_q      <= 1'b0;
      row_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      low_q     <= low_d;
      high_q    <= high_d;
      flags_q   <= flags_d;
      row_vld_q <= row_vld_d;
      rvld_q    <= row_vld_q[row_d];
      row_q     <= row_d;
      ok_q      <= ok_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      v_q  <= v_in;
      vh_q <= fdvs_pkg::clamp_val(value_high_i);
    end
    if (cmd_i.finish) begin
      res_ok_q    <= ok_q;
      res_low_q   <= low_q;
      res_high_q  <= high_q;
      res_fixed_q <= (low_q == high_q);
      res_ev_q    <= flags_q;
    end
  end

  assign status_o.op        = op_q;
  assign status_o.v_gt_vh   = v_q > vh_q;
  assign status_o.v_le_low  = v_q <= low_q;
  assign status_o.v_gt_high = v_q > high_q;
  assign status_o.v_ge_high = v_q >= high_q;
  assign status_o.v_lt_low  = v_q < low_q;
  assign status_o.pres_v    = eff_row[v_bit];
  assign status_o.in_dom    = (v_q >= low_q) && (v_q <= high_q) && eff_row[v_bit];
  assign status_o.lo_eq_hi  = low_q == high_q;
  assign status_o.v_eq_low  = v_q == low_q;
  assign status_o.v_eq_high = v_q == high_q;
  assign status_o.up_done   = up_done;
  assign status_o.dn_done   = dn_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign ok_o        = res_ok_q;
  assign lower_o     = res_low_q;
  assign upper_o     = res_high_q;
  assign is_fixed_o  = res_fixed_q;
  assign events_o    = res_ev_q;

endmodule

// ===== hw/rtl/fdvs_ctrl.sv =====
// operation sequencer of the finite domain value store
module fdvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fdvs_pkg::status_t   status_i,
  output fdvs_pkg::cmd_t      cmd_o
);

  fdvs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdvs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdvs_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = fdvs_pkg::StDecide;
        end
      end
      fdvs_pkg::StDecide: begin
        state_d = fdvs_pkg::StFinish;
        unique case (status_i.op)
          fdvs_pkg::OpRaiseMin: begin
            if (!status_i.v_le_low && !status_i.v_gt_high && !status_i.pres_v) begin
              state_d = fdvs_pkg::StScanUp;
            end
          end
          fdvs_pkg::OpLowerMax: begin
            if (!status_i.v_ge_high && !status_i.v_lt_low && !status_i.pres_v) begin
              state_d = fdvs_pkg::StScanDn;
            end
          end
          fdvs_pkg::OpRemoveValue: begin
            // a removed bound needs the rewritten row before the scan
            if (status_i.in_dom && !status_i.lo_eq_hi &&
                (status_i.v_eq_low || status_i.v_eq_high)) begin
              state_d = fdvs_pkg::StRefresh;
            end
          end
          default: begin
            state_d = fdvs_pkg::StFinish;
          end
        endcase
      end
      fdvs_pkg::StRefresh: begin
        state_d = status_i.v_eq_low ? fdvs_pkg::StScanUp : fdvs_pkg::StScanDn;
      end
      fdvs_pkg::StScanUp: begin
        if (status_i.up_done) begin
          state_d = fdvs_pkg::StFinish;
        end
      end
      fdvs_pkg::StScanDn: begin
        if (status_i.dn_done) begin
          state_d = fdvs_pkg::StFinish;
        end
      end
      fdvs_pkg::StFinish: begin
        if (status_i.out_free) begin
          state_d = fdvs_pkg::StIdle;
        end
      end
      default: begin
        state_d = fdvs_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fdvs_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      fdvs_pkg::StDecide: begin
        unique case (status_i.op)
          fdvs_pkg::OpInit: begin
            if (status_i.v_gt_vh) begin
              cmd_o.set_fail = 1'b1;
            end else begin
              cmd_o.do_init = 1'b1;
            end
          end
          fdvs_pkg::OpRaiseMin: begin
            if (!status_i.v_le_low) begin
              if (status_i.v_gt_high) begin
                cmd_o.set_fail = 1'b1;
              end else begin
                cmd_o.low_to_v = 1'b1;
              end
            end
          end
          fdvs_pkg::OpLowerMax: begin
            if (!status_i.v_ge_high) begin
              if (status_i.v_lt_low) begin
                cmd_o.set_fail = 1'b1;
              end else begin
                cmd_o.high_to_v = 1'b1;
              end
            end
          end
          fdvs_pkg::OpFixValue: begin
            if (status_i.in_dom) begin
              cmd_o.do_fix = 1'b1;
            end else begin
              cmd_o.set_fail = 1'b1;
            end
          end
          fdvs_pkg::OpRemoveValue: begin
            if (status_i.in_dom) begin
              if (status_i.lo_eq_hi) begin
                cmd_o.set_fail = 1'b1;
              end else begin
                cmd_o.do_remove = 1'b1;
              end
            end
          end
          fdvs_pkg::OpTakeEvents: begin
            cmd_o.set_fail = 1'b0;
          end
          default: begin
            cmd_o.set_fail = 1'b1;
          end
        endcase
      end
      fdvs_pkg::StRefresh: begin
        cmd_o = '0;
      end
      fdvs_pkg::StScanUp: begin
        cmd_o.scan_up = 1'b1;
      end
      fdvs_pkg::StScanDn: begin
        cmd_o.scan_dn = 1'b1;
      end
      fdvs_pkg::StFinish: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/finite_domain_value_store.sv =====
// top level of the finite domain value store
//
//   channel  dir  beat payload                               handshake
//   in_i     in   opcode, value, value_high                  valid/ready
//   out_o    out  ok, lower, upper, is_fixed, events         valid/ready
//
// one operation at a time; ready is high only while the sequencer is idle
// a beat is captured while idle, then passes the decide and finish states; removing a bound adds a refresh state, and
// bound scans walk the presence bitmap one 16-value row per cycle (up to 16 rows)
// the result register holds a beat until taken; a new beat is accepted while it waits
// reset: bounds 0 and 255, flags clear, every bitmap row reads as all present
// through per-row valid bits, so there is no clearing pass
module finite_domain_value_store (
  input logic          clk_i,
  input logic          rst_ni,
  fdvs_in_if.sink      in_i,
  fdvs_out_if.source   out_o
);

  fdvs_pkg::cmd_t    cmd;
  fdvs_pkg::status_t status;

  fdvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdvs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (in_i.opcode),
    .value_i      (in_i.value),
    .value_high_i (in_i.value_high),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .ok_o         (out_o.ok),
    .lower_o      (out_o.lower),
    .upper_o      (out_o.upper),
    .is_fixed_o   (out_o.is_fixed),
    .events_o     (out_o.events)
  );

endmodule
